// ===== hw/rtl/mavg_pkg.sv =====
package mavg_pkg;

  // Width of a sample and of its average (signed Q8.8).
  localparam int SAMPLE_W = 16;

  // Width of the window register and of the held-sample count.
  localparam int CNT_W = 6;

  // Window size after reset.
  localparam logic [CNT_W-1:0] WINDOW_RST = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ADD,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

endpackage

// ===== hw/rtl/moving_average_filter.sv =====
// Moving average over the last window_size signed Q8.8 samples, held in a
// ring memory with a running sum. Each request on the input stream yields one
// result: the sum divided by the number of samples held (truncated toward
// zero) and that count. A request is taken only once the result of the one
// before it is in the output register. SUM_W is the running-sum width (16
// plus log2 of the largest window). The bit-serial divider yields one
// quotient bit per cycle. A finished result waits in the output register
// while the next request is taken. Writing the window register empties the
// average; zero acts as a window of one and values above MAX_DEPTH act as
// MAX_DEPTH.
module moving_average_filter #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [15:0] sample
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  // out_tdata: [15:0] average, [21:16] samples_held, [23:22] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mavg_pkg::CNT_W-1:0]    cfg_data
);

  localparam int CNT_W   = mavg_pkg::CNT_W;
  localparam int SMP_W   = mavg_pkg::SAMPLE_W;
  localparam int WIN_LIM = (1 << CNT_W) - 1;
  localparam int WIN_MAX = (MAX_DEPTH < WIN_LIM) ? MAX_DEPTH : WIN_LIM;
  localparam int SUM_W   = SMP_W + $clog2(WIN_MAX);
  localparam int SLOT_W  = $clog2(MAX_DEPTH);
  localparam int CMP_W   = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;

  mavg_pkg::state_t state_r, state_nxt;

  logic signed [SMP_W-1:0]  ring_r [MAX_DEPTH];
  logic signed [SMP_W-1:0]  rd_data_r;
  logic signed [SMP_W-1:0]  sample_r;

  logic [CNT_W-1:0]         window_r;
  logic [CNT_W-1:0]         win;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [SLOT_W:0]          slot_inc;
  logic [CNT_W-1:0]         fill_r;
  logic                     full;
  logic signed [SUM_W-1:0]  sum_r;

  logic                     in_acc;
  logic                     out_free;
  logic                     div_start;
  logic                     div_busy;
  logic [SUM_W-1:0]         div_quo;
  logic                     div_neg;
  logic [SMP_W-1:0]         avg;

  logic                     out_valid_r;
  logic [SMP_W-1:0]         out_avg_r;
  logic [CNT_W-1:0]         out_held_r;
  logic                     load_out;

  // Window in force: the register forced into 1..WIN_MAX.
  always_comb begin
    if (window_r == '0) begin
      win = CNT_W'(1);
    end else if (window_r > CNT_W'(WIN_MAX)) begin
      win = CNT_W'(WIN_MAX);
    end else begin
      win = window_r;
    end
  end

  assign full     = (fill_r >= win);
  assign slot_inc = {1'b0, slot_r} + 1'b1;
  assign slot_nxt = (CMP_W'(slot_inc) == CMP_W'(win)) ? '0 : slot_inc[SLOT_W-1:0];
  assign in_acc   = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;
  assign avg      = div_neg ? (~div_quo[SMP_W-1:0] + 1'b1) : div_quo[SMP_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mavg_pkg::ST_IDLE:   if (in_tvalid) state_nxt = mavg_pkg::ST_UPDATE;
      mavg_pkg::ST_UPDATE: state_nxt = mavg_pkg::ST_ADD;
      mavg_pkg::ST_ADD:    state_nxt = mavg_pkg::ST_START;
      mavg_pkg::ST_START:  state_nxt = mavg_pkg::ST_DIVIDE;
      mavg_pkg::ST_DIVIDE: if (!div_busy) state_nxt = mavg_pkg::ST_OUTPUT;
      mavg_pkg::ST_OUTPUT: if (out_free) state_nxt = mavg_pkg::ST_IDLE;
      default:             state_nxt = mavg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mavg_pkg::ST_IDLE:   in_tready = 1'b1;
      mavg_pkg::ST_START:  div_start = 1'b1;
      mavg_pkg::ST_OUTPUT: load_out  = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ring memory: the oldest sample is read as the request is taken and the
  // new one is written over it in the following cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= ring_r[slot_r];
      sample_r  <= in_tdata;
    end
    if (state_r == mavg_pkg::ST_UPDATE) begin
      ring_r[slot_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= mavg_pkg::WINDOW_RST;
      slot_r   <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else if (cfg_valid) begin
      window_r <= cfg_data;
      slot_r   <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else begin
      case (state_r)
        mavg_pkg::ST_UPDATE: begin
          slot_r <= slot_nxt;
          if (full) begin
            sum_r <= sum_r - {{(SUM_W-SMP_W){rd_data_r[SMP_W-1]}}, rd_data_r};
          end else begin
            fill_r <= fill_r + 1'b1;
          end
        end
        mavg_pkg::ST_ADD: begin
          sum_r <= sum_r + {{(SUM_W-SMP_W){sample_r[SMP_W-1]}}, sample_r};
        end
        default: begin
        end
      endcase
    end
  end

  mavg_div #(
    .DVD_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .busy     (div_busy),
    .quotient (div_quo),
    .negative (div_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg_r  <= avg;
      out_held_r <= fill_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_held_r, out_avg_r};

endmodule

// ===== hw/rtl/mavg_div.sv =====
module mavg_div #(
  parameter int DVD_W = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [DVD_W-1:0]        dividend,
  input  logic [mavg_pkg::CNT_W-1:0]     divisor,
  output logic                           busy,
  output logic [DVD_W-1:0]               quotient,
  output logic                           negative
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic                          busy_r, busy_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [DVD_W-1:0]              quo_r, quo_nxt;
  logic [mavg_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [mavg_pkg::CNT_W-1:0]    dvs_r;
  logic                          neg_r;
  logic [mavg_pkg::CNT_W:0]      shifted;
  logic [mavg_pkg::CNT_W+1:0]    trial;
  logic                          fits;

  // One restoring step per cycle: the dividend magnitude shifts out of the
  // top of the quotient register into the remainder while quotient bits
  // shift in at the bottom.
  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    fits     = ~trial[mavg_pkg::CNT_W+1];
    rem_nxt  = fits ? trial[mavg_pkg::CNT_W-1:0] : shifted[mavg_pkg::CNT_W-1:0];
    quo_nxt  = {quo_r[DVD_W-2:0], fits};
    step_nxt = step_r + 1'b1;
    busy_nxt = (step_r != STEP_W'(DVD_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[DVD_W-1];
      quo_r  <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
      step_r <= '0;
    end else if (busy_r) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign negative = neg_r;

endmodule

// ===== tb/tb_moving_average_filter.sv =====
module tb_moving_average_filter;

  localparam int SAMPLE_W = mavg_pkg::SAMPLE_W;
  localparam int CNT_W = mavg_pkg::CNT_W;
  localparam int RING_DEPTH = 32;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_SAMPLES = 800;
  localparam int CALM_AFTER = 700;

  // Field layout of out_tdata, lowest bits last.
  typedef struct packed {
    logic [1:0]          pad;
    logic [CNT_W-1:0]    held;
    logic [SAMPLE_W-1:0] average;
  } avg_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SAMPLE_W-1:0] value;
    logic                typed;
    logic [SAMPLE_W-1:0] want_avg;
    logic [CNT_W-1:0]    want_held;
  } script_row_t;

  typedef enum int {
    FILL_FULL_RANGE,
    FILL_EXTREMES,
    FILL_NEAR_ZERO,
    FILL_ALL_MIN,
    FILL_ALL_MAX
  } fill_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [23:0]         out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_W-1:0]    cfg_data = '0;

  moving_average_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the filter state.
  logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
  logic [CNT_W-1:0]           window_reg = mavg_pkg::WINDOW_RST;
  int unsigned                next_slot = 0;
  int unsigned                held_count = 0;
  longint                     sum_held = 0;

  avg_word_t   pending_averages [$];
  script_row_t script [];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned averages_checked = 0;
  int unsigned window_writes = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;
  logic        tx_choppy = 1'b1;
  logic        rx_choppy = 1'b1;

  function automatic avg_word_t average_after(input logic signed [SAMPLE_W-1:0] s);
    int unsigned win;
    int unsigned slot;
    longint      quotient;
    avg_word_t   r;
    win = (window_reg == 0) ? 1 : ((window_reg > RING_DEPTH) ? RING_DEPTH : window_reg);
    slot = (next_slot < win) ? next_slot : 0;
    if (held_count < win) begin
      held_count++;
    end else begin
      sum_held -= ring_copy[slot];
    end
    ring_copy[slot] = s;
    sum_held += s;
    next_slot = (slot + 1) % win;
    // SystemVerilog division of signed integers truncates toward zero.
    quotient = sum_held / longint'(held_count);
    r.pad = '0;
    r.held = held_count[CNT_W-1:0];
    r.average = quotient[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_mode_t mode);
    logic [SAMPLE_W-1:0] s;
    case (mode)
      FILL_ALL_MIN: s = 16'h8000;
      FILL_ALL_MAX: s = 16'h7fff;
      FILL_EXTREMES: begin
        case ($urandom_range(0, 5))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'hffff;
          4: s = 16'h0001;
          default: s = SAMPLE_W'($urandom_range(0, 16'hffff));
        endcase
      end
      FILL_NEAR_ZERO: s = SAMPLE_W'($urandom_range(0, 15) - 8);
      default: s = SAMPLE_W'($urandom_range(0, 16'hffff));
    endcase
    return s;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic maybe_pause();
    if (!calm && tx_choppy && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Offers one sample and, once the request is taken, records its expected average.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input avg_word_t want);
    avg_word_t predicted;
    in_tdata <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = average_after(s);
    pending_averages.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // The window register is only written once the filter has gone quiet.
  task automatic set_window(input logic [CNT_W-1:0] w);
    in_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    window_reg = w;
    next_slot = 0;
    held_count = 0;
    sum_held = 0;
    window_writes++;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (!calm && rx_choppy && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 13);
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    avg_word_t got;
    avg_word_t want;
    got = avg_word_t'(out_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_averages.size() == 0) begin
        flag_error($sformatf("unexpected result: average %h held %0d", got.average, got.held));
      end else begin
        want = pending_averages.pop_front();
        averages_checked++;
        if (got.average !== want.average || got.held !== want.held || got.pad !== 2'b00)
          flag_error($sformatf("mismatch: average %h held %0d pad %b, expected %h held %0d",
                               got.average, got.held, got.pad, want.average, want.held));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_averages.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned   random_sent;
    int unsigned   phase;
    int unsigned   phase_len;
    fill_mode_t    mode;
    logic [CNT_W-1:0] w;
    avg_word_t     typed_word;

    script = '{
      '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff, 6'd1},
      '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff, 6'd2},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h2aaa, 6'd3},
      '{ROW_WINDOW, 16'd1,    1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 6'd1},
      '{ROW_SAMPLE, 16'h0001, 1'b1, 16'h0001, 6'd1},
      // A window of zero behaves as a window of one.
      '{ROW_WINDOW, 16'd0,    1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'hffff, 1'b1, 16'hffff, 6'd1},
      '{ROW_SAMPLE, 16'h1234, 1'b1, 16'h1234, 6'd1},
      // Negative halves must truncate toward zero.
      '{ROW_WINDOW, 16'd2,    1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'hffff, 1'b1, 16'hffff, 6'd1},
      '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000, 6'd2},
      '{ROW_SAMPLE, 16'hfffd, 1'b1, 16'hffff, 6'd2},
      '{ROW_SAMPLE, 16'h0003, 1'b1, 16'h0000, 6'd2},
      '{ROW_WINDOW, 16'd3,    1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h0006, 1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h0007, 1'b0, 16'h0000, 6'd0},
      // Windows above the ring depth are clamped to it.
      '{ROW_WINDOW, 16'd33,   1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h0100, 1'b1, 16'h0100, 6'd1},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hc080, 6'd2},
      '{ROW_WINDOW, 16'd63,   1'b0, 16'h0000, 6'd0},
      '{ROW_SAMPLE, 16'h7fff, 1'b0, 16'h0000, 6'd0},
      '{ROW_WINDOW, 16'd32,   1'b0, 16'h0000, 6'd0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WINDOW) begin
        set_window(script[i].value[CNT_W-1:0]);
      end else begin
        typed_word = '{pad: 2'b00, held: script[i].want_held, average: script[i].want_avg};
        maybe_pause();
        send_sample(script[i].value, script[i].typed, typed_word);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      case (phase)
        // A full window of the most negative and most positive samples
        // drives the running sum to both ends of its range.
        0: begin w = 6'd32; mode = FILL_ALL_MIN;    phase_len = 40; end
        1: begin w = 6'd63; mode = FILL_ALL_MAX;    phase_len = 40; end
        2: begin w = 6'd1;  mode = FILL_EXTREMES;   phase_len = 20; end
        3: begin w = 6'd0;  mode = FILL_NEAR_ZERO;  phase_len = 20; end
        4: begin w = 6'd2;  mode = FILL_NEAR_ZERO;  phase_len = 30; end
        default: begin
          case ($urandom_range(0, 5))
            0: w = 6'd32;
            1: w = 6'd1;
            2: w = CNT_W'($urandom_range(2, 8));
            default: w = CNT_W'($urandom_range(0, 63));
          endcase
          mode = fill_mode_t'($urandom_range(0, 2));
          phase_len = $urandom_range(10, 80);
        end
      endcase
      tx_choppy = ($urandom_range(0, 3) != 0);
      rx_choppy = ($urandom_range(0, 3) != 0);
      set_window(w);
      repeat (phase_len) begin
        calm = (random_sent >= CALM_AFTER);
        maybe_pause();
        send_sample(pick_sample(mode), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 20) @(posedge clk);

    $display("Sent %0d samples over %0d window settings, including zero, one, 32 and 63.",
             samples_sent, window_writes);
    $display("Checked %0d averages, with full windows of extreme samples and stalls on both sides.",
             averages_checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_div.sv
hw/rtl/moving_average_filter.sv
tb/tb_moving_average_filter.sv
